/* src/sht_pkg.sv */
// ----------------------------------------------------------------------------
// sht_pkg
// Shared types and constants of the spatial hash table: table geometry,
// hash primes, slot layout, job kinds, status codes and FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package sht_pkg;

   localparam int TABLE_SIZE  = 32768;
   localparam int SLOT_BITS   = $clog2(TABLE_SIZE);
   localparam int ITEM_COUNT  = 256;
   localparam int ITEM_BITS   = 8;
   localparam int FIELD_BITS  = 16;              // width of one coordinate field
   localparam int COORD_BITS  = 16;              // bits of a coordinate that count
   localparam int KEY_BITS    = 3 * COORD_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

   localparam int REQ_DATA_BITS = 3 * FIELD_BITS + ITEM_BITS;
   localparam int RSP_DATA_BITS = ITEM_BITS;
   localparam int OP_BITS       = 2;
   localparam int STATUS_BITS   = 2;

   localparam logic [31:0] HASH_PX = 32'd73856093;
   localparam logic [31:0] HASH_PY = 32'd19349663;
   localparam logic [31:0] HASH_PZ = 32'd83492791;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      JOB_INSERT,
      JOB_LOOKUP,
      JOB_REMOVE,
      JOB_REJECT
   } job_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_USED  = 2'd1,
      MARK_TOMB  = 2'd2
   } mark_type;

   typedef struct packed {
      mark_type               mark;
      logic [ITEM_BITS-1:0]   item;
      logic [KEY_BITS-1:0]    key;
   } slot_word_type;

   localparam int SLOT_WORD_BITS = $bits(slot_word_type);

   typedef struct packed {
      job_type                kind;
      logic [ITEM_BITS-1:0]   item;
      logic [KEY_BITS-1:0]    key;
      logic [SLOT_BITS-1:0]   home;
   } job_entry_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_PROBE
   } back_state_type;

endpackage

`default_nettype wire

/* src/sht_ram.sv */
// ----------------------------------------------------------------------------
// sht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/sht_front.sv */
// ----------------------------------------------------------------------------
// sht_front
// Accepts request transactions, classifies them and computes the home slot
// in two registered stages (sign extension, then the three hash products).
// ----------------------------------------------------------------------------
`default_nettype none

module sht_front import sht_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     clearing,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [OP_BITS-1:0]       req_tuser,
   output      logic                     push,
   output      job_entry_type            push_entry,
   input  wire logic                     q_full
);

   logic                 v1_ff, v1_in;
   job_type              job1_ff, job1_in;
   logic [ITEM_BITS-1:0] item1_ff;
   logic [31:0]          sx1_ff, sy1_ff, sz1_ff;

   logic                 v2_ff, v2_in;
   job_type              job2_ff;
   logic [ITEM_BITS-1:0] item2_ff;
   logic [KEY_BITS-1:0]  key2_ff;
   logic [31:0]          px2_ff, py2_ff, pz2_ff;

   logic                 adv1, adv2, take;
   logic [FIELD_BITS-1:0] fx, fy, fz;
   logic [ITEM_BITS-1:0]  fitem;
   logic [31:0]          hash;

   assign fx    = req_tdata[FIELD_BITS-1:0];
   assign fy    = req_tdata[2*FIELD_BITS-1:FIELD_BITS];
   assign fz    = req_tdata[3*FIELD_BITS-1:2*FIELD_BITS];
   assign fitem = req_tdata[REQ_DATA_BITS-1:3*FIELD_BITS];

   assign push       = v2_ff && !q_full;
   assign adv2       = !v2_ff || push;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1 && !clearing;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      unique case (op_type'(req_tuser))
         OP_INSERT: job1_in = (32'(fitem) >= ITEM_COUNT) ? JOB_REJECT : JOB_INSERT;
         OP_LOOKUP: job1_in = JOB_LOOKUP;
         OP_REMOVE: job1_in = JOB_REMOVE;
         default:   job1_in = JOB_REJECT;
      endcase
   end

   always_comb begin
      v1_in = v1_ff;
      v2_in = v2_ff;
      if (adv1) begin
         v1_in = take;
      end
      if (adv2) begin
         v2_in = v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // stage 1: classify and sign-extend from the coordinate width
   always_ff @(posedge clock) begin
      if (take) begin
         job1_ff  <= job1_in;
         item1_ff <= fitem;
         sx1_ff   <= 32'(signed'(fx[COORD_BITS-1:0]));
         sy1_ff   <= 32'(signed'(fy[COORD_BITS-1:0]));
         sz1_ff   <= 32'(signed'(fz[COORD_BITS-1:0]));
      end
   end

   // stage 2: hash products, wrapping at 32 bits
   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         job2_ff  <= job1_ff;
         item2_ff <= item1_ff;
         key2_ff  <= {sz1_ff[COORD_BITS-1:0], sy1_ff[COORD_BITS-1:0],
                      sx1_ff[COORD_BITS-1:0]};
         px2_ff   <= sx1_ff * HASH_PX;
         py2_ff   <= sy1_ff * HASH_PY;
         pz2_ff   <= sz1_ff * HASH_PZ;
      end
   end

   assign hash = px2_ff ^ py2_ff ^ pz2_ff;

   always_comb begin
      push_entry.kind = job2_ff;
      push_entry.item = item2_ff;
      push_entry.key  = key2_ff;
      push_entry.home = hash[SLOT_BITS-1:0];
   end

endmodule

`default_nettype wire

/* src/sht_queue.sv */
// ----------------------------------------------------------------------------
// sht_queue
// Short FIFO of classified jobs between the front and the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sht_queue import sht_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire job_entry_type push_entry,
   input  wire logic          pop,
   output      job_entry_type head,
   output      logic          full,
   output      logic          empty
);

   job_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_BITS:0]   count_ff, count_in;

   assign full  = (count_ff == (QUEUE_BITS + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

/* src/sht_back.sv */
// ----------------------------------------------------------------------------
// sht_back
// Probe engine: clears the slot marks after reset, then walks the probe
// chain of each job one slot per cycle and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module sht_back import sht_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   output      logic                      clearing,
   input  wire job_entry_type             q_head,
   input  wire logic                      q_empty,
   output      logic                      pop,
   output      logic                      ram_wr_en,
   output      logic [SLOT_BITS-1:0]      ram_wr_addr,
   output      logic [SLOT_WORD_BITS-1:0] ram_wr_data,
   output      logic [SLOT_BITS-1:0]      ram_rd_addr,
   input  wire logic [SLOT_WORD_BITS-1:0] ram_rd_data,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   output      logic [STATUS_BITS-1:0]    rsp_tuser
);

   back_state_type       state_ff, state_in;
   job_entry_type        job_ff, job_in;
   logic [SLOT_BITS-1:0] addr_ff, addr_in;
   logic [SLOT_BITS-1:0] cnt_ff, cnt_in;
   logic [SLOT_BITS-1:0] clr_ff, clr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [ITEM_BITS-1:0] rsp_found_ff;

   slot_word_type        slot;
   slot_word_type        new_slot;
   logic                 done, want_wr, finish, out_free, last;
   status_type           res_status;
   logic [ITEM_BITS-1:0] res_found;

   assign slot     = slot_word_type'(ram_rd_data);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign last     = (cnt_ff == '1);
   assign clearing = (state_ff == BK_CLEAR);

   // decide on the slot read for the current probe
   always_comb begin
      done       = 1'b0;
      want_wr    = 1'b0;
      res_status = ST_NOT_FOUND;
      res_found  = '0;
      new_slot   = slot;
      unique case (job_ff.kind)
         JOB_INSERT: begin
            if (slot.mark != MARK_USED) begin
               done          = 1'b1;
               want_wr       = 1'b1;
               res_status    = ST_DONE;
               new_slot.mark = MARK_USED;
               new_slot.item = job_ff.item;
               new_slot.key  = job_ff.key;
            end else if (last) begin
               done       = 1'b1;
               res_status = ST_FULL;
            end
         end
         JOB_LOOKUP: begin
            if (slot.mark == MARK_EMPTY) begin
               done = 1'b1;
            end else if (slot.mark == MARK_USED && slot.key == job_ff.key) begin
               done       = 1'b1;
               res_status = ST_DONE;
               res_found  = slot.item;
            end else if (last) begin
               done = 1'b1;
            end
         end
         JOB_REMOVE: begin
            if (slot.mark == MARK_EMPTY) begin
               done = 1'b1;
            end else if (slot.mark == MARK_USED && slot.item == job_ff.item) begin
               done          = 1'b1;
               want_wr       = 1'b1;
               res_status    = ST_DONE;
               new_slot.mark = MARK_TOMB;
            end else if (last) begin
               done = 1'b1;
            end
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop         = 1'b0;
      finish      = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = SLOT_WORD_BITS'(new_slot);
      addr_in     = addr_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      job_in      = job_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
         end
         BK_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               job_in  = q_head;
               addr_in = q_head.home;
               cnt_in  = '0;
            end
         end
         BK_PROBE: begin
            if (done) begin
               // hold the address while the response register is busy
               finish    = out_free;
               ram_wr_en = want_wr && out_free;
            end else begin
               addr_in = addr_ff + 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_rd_addr = addr_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clr_ff == '1) state_in = BK_IDLE;
         BK_IDLE:  if (!q_empty) state_in = BK_PROBE;
         BK_PROBE: if (finish) state_in = BK_IDLE;
         default:  state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      addr_ff <= addr_in;
      cnt_ff  <= cnt_in;
      if (finish) begin
         rsp_status_ff <= res_status;
         rsp_found_ff  <= res_found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_found_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

/* src/spatial_hash_table_top.sv */
// Flow: requests pass the front stages and the job queue, so new ones
// are taken while the probe engine still works on an earlier job, until
// these fill; the probe engine handles one job at a time over the single
// read port of the slot memory.
// Reset: synchronous; afterwards the slot marks are cleared in one pass over
// the table, during which req_tready stays low.
// ----------------------------------------------------------------------------
// spatial_hash_table_top
// Open-addressed, linearly probed spatial hash keyed by 3-D grid coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module spatial_hash_table_top import sht_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,  // coord_x, coord_y, coord_z, item_index
   input  wire logic [OP_BITS-1:0]       req_tuser,  // op
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata,  // found_index
   output      logic [STATUS_BITS-1:0]   rsp_tuser   // status
);

   logic                      clearing;
   logic                      push, pop, q_full, q_empty;
   job_entry_type             push_entry, q_head;
   logic                      ram_wr_en;
   logic [SLOT_BITS-1:0]      ram_wr_addr, ram_rd_addr;
   logic [SLOT_WORD_BITS-1:0] ram_wr_data, ram_rd_data;

   sht_front u_front (
      .clock      (clock),
      .reset      (reset),
      .clearing   (clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_entry (push_entry),
      .q_full     (q_full)
   );

   sht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   sht_ram #(
      .WIDTH (SLOT_WORD_BITS),
      .DEPTH (TABLE_SIZE)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sht_back u_back (
      .clock       (clock),
      .reset       (reset),
      .clearing    (clearing),
      .q_head      (q_head),
      .q_empty     (q_empty),
      .pop         (pop),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

/* src/sht_checker.sv */
// ----------------------------------------------------------------------------
// sht_checker
// Port-level checks of the spatial hash table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sht_checker import sht_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tready,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic [STATUS_BITS-1:0]   rsp_tuser
);

   // the clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request side open or response shown right after reset");

   // a stalled response transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ST_DONE || rsp_tuser == ST_NOT_FOUND || rsp_tuser == ST_FULL)
      else $error("undefined status code");

   // only a successful lookup carries an item index
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DONE |-> rsp_tdata == '0)
      else $error("item index on a failed transaction");

endmodule

bind spatial_hash_table_top sht_checker u_checker (.*);

`default_nettype wire

/* test/sht_answer_checker.sv */
// ----------------------------------------------------------------------------
// sht_answer_checker
// Watches both streams of the spatial hash table, predicts the answer of
// every accepted request from a private copy of the slot table, and compares
// each accepted response with the oldest predicted answer.
// ----------------------------------------------------------------------------
module sht_answer_checker import sht_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // coord_x, coord_y, coord_z, item_index
   input  logic [OP_BITS-1:0]       req_tuser,  // op
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,  // found_index
   input  logic [STATUS_BITS-1:0]   rsp_tuser,  // status
   output int                       mismatch_count,
   output int                       answers_due
);

   typedef struct packed {
      status_type             status;
      logic [ITEM_BITS-1:0]   found;
   } answer_type;

   mark_type             mark_tbl [TABLE_SIZE];
   logic [KEY_BITS-1:0]  key_tbl  [TABLE_SIZE];
   logic [ITEM_BITS-1:0] item_tbl [TABLE_SIZE];
   answer_type           answer_q [$];

   // keep the counting bits of a coordinate and sign-extend them to 32 bits
   function automatic logic [31:0] widen(logic [FIELD_BITS-1:0] raw);
      logic [COORD_BITS-1:0] kept;
      kept = raw[COORD_BITS-1:0];
      return {{(32-COORD_BITS){kept[COORD_BITS-1]}}, kept};
   endfunction

   function automatic answer_type run_request(op_type op, logic [REQ_DATA_BITS-1:0] data);
      logic [31:0]          hx, hy, hz;
      logic [SLOT_BITS-1:0] slot;
      logic [KEY_BITS-1:0]  key;
      logic [ITEM_BITS-1:0] item;
      answer_type           ans;
      hx   = widen(data[0 +: FIELD_BITS]) * HASH_PX;
      hy   = widen(data[FIELD_BITS +: FIELD_BITS]) * HASH_PY;
      hz   = widen(data[2*FIELD_BITS +: FIELD_BITS]) * HASH_PZ;
      slot = SLOT_BITS'(hx ^ hy ^ hz);
      key  = {data[2*FIELD_BITS +: COORD_BITS], data[FIELD_BITS +: COORD_BITS],
              data[0 +: COORD_BITS]};
      item = data[3*FIELD_BITS +: ITEM_BITS];
      ans.status = ST_NOT_FOUND;
      ans.found  = '0;
      case (op)
         OP_INSERT: begin
            if (int'(item) < ITEM_COUNT) begin
               ans.status = ST_FULL;
               for (int n = 0; n < TABLE_SIZE; n++) begin
                  if (mark_tbl[slot] != MARK_USED) begin
                     mark_tbl[slot] = MARK_USED;
                     key_tbl[slot]  = key;
                     item_tbl[slot] = item;
                     ans.status     = ST_DONE;
                     break;
                  end
                  slot = slot + 1'b1;
               end
            end
         end
         OP_LOOKUP: begin
            for (int n = 0; n < TABLE_SIZE; n++) begin
               if (mark_tbl[slot] == MARK_EMPTY) break;
               if (mark_tbl[slot] == MARK_USED && key_tbl[slot] == key) begin
                  ans.status = ST_DONE;
                  ans.found  = item_tbl[slot];
                  break;
               end
               slot = slot + 1'b1;
            end
         end
         OP_REMOVE: begin
            // the stored coordinates play no part here, only the item
            for (int n = 0; n < TABLE_SIZE; n++) begin
               if (mark_tbl[slot] == MARK_EMPTY) break;
               if (mark_tbl[slot] == MARK_USED && item_tbl[slot] == item) begin
                  mark_tbl[slot] = MARK_TOMB;
                  ans.status     = ST_DONE;
                  break;
               end
               slot = slot + 1'b1;
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         foreach (mark_tbl[i]) mark_tbl[i] = MARK_EMPTY;
         answer_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, actual status %0d index %0d",
                        $time, rsp_tuser, rsp_tdata);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = answer_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status mismatch, expected %0d actual %0d",
                           $time, want.status, rsp_tuser);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_tdata !== want.found) begin
                  $display("%0t: found_index mismatch, expected %0d actual %0d",
                           $time, want.found, rsp_tdata);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            answer_q.push_back(run_request(op_type'(req_tuser), req_tdata));
      end
      answers_due <= answer_q.size();
   end

endmodule

/* test/tb_spatial_hash_table_top.sv */
// ----------------------------------------------------------------------------
// tb_spatial_hash_table_top
// Drives inserts, lookups, removes and unused opcodes into the spatial hash
// table with random gaps and stalls on both streams: a directed opening, then
// a random mix built around colliding coordinates.
// ----------------------------------------------------------------------------
module tb_spatial_hash_table_top;
   import sht_pkg::*;

   localparam int     RANDOM_ITEMS    = 1380;
   localparam int     KEY_FAMILIES    = 16;
   localparam int     HOLD_OFF_CYCLES = 300;
   localparam longint CYCLE_LIMIT     = 3_000_000;

   typedef logic [3*FIELD_BITS-1:0] grid_point_type;   // {z, y, x}

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [OP_BITS-1:0]       req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [STATUS_BITS-1:0]   rsp_tuser;
   int                       mismatch_count;
   int                       answers_due;
   longint                   cycle_count = 0;
   bit                       gapless;
   bit                       item_live  [ITEM_COUNT];
   grid_point_type           item_key   [ITEM_COUNT];
   grid_point_type           family_key [KEY_FAMILIES];

   spatial_hash_table_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sht_answer_checker hash_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .answers_due    (answers_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic grid_point_type point_at(logic [FIELD_BITS-1:0] x, y, z);
      return {z, y, x};
   endfunction

   function automatic grid_point_type any_point();
      return grid_point_type'({$urandom, $urandom});
   endfunction

   // Flipping the top counting bit of a coordinate moves it by 2^15, which the
   // hash maps onto the same home slot: the eight flip patterns share a home.
   function automatic grid_point_type same_home(grid_point_type p);
      logic [2:0] flips;
      flips = 3'($urandom);
      return p ^ {flips[2], {(FIELD_BITS-1){1'b0}}, flips[1], {(FIELD_BITS-1){1'b0}},
                  flips[0], {(FIELD_BITS-1){1'b0}}};
   endfunction

   function automatic int find_item(bit live);
      int start;
      start = $urandom_range(0, ITEM_COUNT-1);
      for (int n = 0; n < ITEM_COUNT; n++)
         if (item_live[(start + n) % ITEM_COUNT] == live) return (start + n) % ITEM_COUNT;
      return -1;
   endfunction

   function automatic grid_point_type pick_point();
      int held;
      held = find_item(1'b1);
      case ($urandom_range(0, 3))
         0:       return any_point();
         3:       return (held >= 0) ? item_key[held] : any_point();
         default: return same_home(family_key[$urandom_range(0, KEY_FAMILIES-1)]);
      endcase
   endfunction

   task automatic offer(op_type op, grid_point_type point, logic [ITEM_BITS-1:0] item);
      int gap;
      gap = gapless ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {item, point};
      req_tuser  <= op;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic store(grid_point_type point, logic [ITEM_BITS-1:0] item);
      offer(OP_INSERT, point, item);
      item_live[item] = 1'b1;
      item_key[item]  = point;
   endtask

   task automatic evict(grid_point_type point, logic [ITEM_BITS-1:0] item);
      offer(OP_REMOVE, point, item);
      item_live[item] = 1'b0;
   endtask

   // hold the request stream until every answer is back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due != 0) @(posedge clock);
   endtask

   // response side: random stalls, with two long hold-offs to back the block up
   initial begin
      int gap;
      int taken;
      taken = 0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = gapless ? 0 : $urandom_range(0, 15);
         if (taken == 150 || taken == 900) gap = HOLD_OFF_CYCLES;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   initial begin
      int choice;
      int spare;
      int held;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_INSERT;
      gapless    = 1'b0;
      foreach (family_key[i]) family_key[i] = any_point();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table, unused opcode, extremes
      offer(OP_LOOKUP, point_at('0, '0, '0), '0);
      offer(OP_REMOVE, point_at('0, '0, '0), '0);
      offer(OP_UNUSED, '1, '1);
      store(point_at(16'h8000, 16'h8000, 16'h8000), 8'hFF);
      store(point_at(16'h7FFF, 16'h7FFF, 16'h7FFF), 8'h00);
      offer(OP_LOOKUP, point_at(16'h8000, 16'h8000, 16'h8000), '0);
      offer(OP_LOOKUP, point_at(16'h7FFF, 16'h7FFF, 16'h7FFF), '0);
      // duplicate key, then a different point on the same home slot
      store(point_at(16'h8000, 16'h8000, 16'h8000), 8'd1);
      store(point_at(16'h0000, 16'h8000, 16'h8000), 8'd2);
      offer(OP_LOOKUP, point_at(16'h8000, 16'h8000, 16'h8000), '0);
      // tombstone must not cut the chain, and a later insert reuses it
      evict(point_at(16'h8000, 16'h8000, 16'h8000), 8'hFF);
      offer(OP_LOOKUP, point_at(16'h8000, 16'h8000, 16'h8000), '0);
      offer(OP_LOOKUP, point_at(16'h0000, 16'h8000, 16'h8000), '0);
      store(point_at(16'h8000, 16'h8000, 16'h8000), 8'd3);
      offer(OP_LOOKUP, point_at(16'h8000, 16'h8000, 16'h8000), '0);
      // remove matches the item only, not the coordinates
      evict(point_at(16'h8000, 16'h0000, 16'h8000), 8'd2);
      evict(point_at(16'h0000, 16'h8000, 16'h8000), 8'd2);
      offer(OP_REMOVE, point_at(16'd1, 16'd2, 16'd3), 8'd77);
      offer(OP_LOOKUP, point_at(16'h0000, 16'h8000, 16'h8000), '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 64 == 0) gapless = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_ITEMS / 2) settle();
         choice = $urandom_range(0, 99);
         spare  = find_item(1'b0);
         held   = find_item(1'b1);
         if ((choice < 40 && spare >= 0) || held < 0) begin
            store(pick_point(), spare[ITEM_BITS-1:0]);
         end else if (choice < 40 || (choice >= 70 && choice < 95)) begin
            // an absent item is never found; a live one always is from its home
            if (spare >= 0 && $urandom_range(0, 3) == 0)
               offer(OP_REMOVE, pick_point(), spare[ITEM_BITS-1:0]);
            else
               evict(same_home(item_key[held]), held[ITEM_BITS-1:0]);
         end else if (choice < 70) begin
            offer(OP_LOOKUP, pick_point(), ITEM_BITS'($urandom));
         end else begin
            offer(OP_UNUSED, pick_point(), ITEM_BITS'($urandom));
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
src/sht_pkg.sv
src/sht_ram.sv
src/sht_front.sv
src/sht_queue.sv
src/sht_back.sv
src/spatial_hash_table_top.sv
src/sht_checker.sv
test/sht_answer_checker.sv
test/tb_spatial_hash_table_top.sv
